[src/plai_pkg.sv]
// ----------------------------------------------------------------------------
// plai_pkg
// Shared types and constants of the piecewise linear anchor interpolator.
// ----------------------------------------------------------------------------
package plai_pkg;

    localparam int unsigned POS_W  = 10;
    localparam int unsigned VAL_W  = 64;
    localparam int unsigned STEP_W = 32;
    localparam int unsigned OFF_W  = 12;
    localparam int unsigned PROD_W = VAL_W + POS_W;

    // configuration register indexes
    localparam logic [1:0] CFG_BLOCK_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_FIRST_SAMPLE   = 2'd1;
    localparam logic [1:0] CFG_FINAL_SAMPLE   = 2'd2;
    localparam logic [1:0] CFG_ANCHORS_IN_USE = 2'd3;

    // input item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // one stored anchor
    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  val;
        logic [STEP_W-1:0] step;
    } anchor_t;

    // sequencer of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_SELECT,
        ST_CALC,
        ST_FINISH
    } state_t;

    // interpolation unit sequencer
    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_DIV,
        L_DONE
    } lerp_state_t;

endpackage

[src/plai_cell.sv]
// ----------------------------------------------------------------------------
// plai_cell
// One anchor cell of the ring: loads on a write, passes its anchor on a shift.
// ----------------------------------------------------------------------------
module plai_cell (
    input  logic              clk,
    input  logic              load_en,
    input  plai_pkg::anchor_t load_anchor,
    input  logic              shift_en,
    input  plai_pkg::anchor_t shift_in,
    output plai_pkg::anchor_t cur
);

    plai_pkg::anchor_t anchor_reg;
    plai_pkg::anchor_t anchor_next;

    // write has priority, else take the neighbor's anchor
    always_comb
    begin
        anchor_next = anchor_reg;
        if (load_en)
        begin
            anchor_next = load_anchor;
        end
        else if (shift_en)
        begin
            anchor_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        anchor_reg <= anchor_next;
    end

    assign cur = anchor_reg;

endmodule

[src/plai_lerp.sv]
// ----------------------------------------------------------------------------
// plai_lerp
// Serial interpolation unit: begin + trunc((end - begin) * off / span).
// ----------------------------------------------------------------------------
module plai_lerp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [plai_pkg::VAL_W-1:0]         begin_val,
    input  logic [plai_pkg::VAL_W-1:0]         end_val,
    input  logic signed [plai_pkg::OFF_W-1:0]  off,
    input  logic [plai_pkg::POS_W-1:0]         span,
    output logic                               busy,
    output logic                               done,
    output logic [plai_pkg::VAL_W-1:0]         result
);

    localparam int unsigned MUL_STEPS = plai_pkg::POS_W;
    localparam int unsigned DIV_STEPS = plai_pkg::PROD_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    plai_pkg::lerp_state_t state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [plai_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [plai_pkg::PROD_W-1:0]   mcand_reg, mcand_next;
    logic [plai_pkg::POS_W-1:0]    mult_reg, mult_next;
    logic [plai_pkg::POS_W-1:0]    span_reg, span_next;
    logic [plai_pkg::POS_W-1:0]    rem_reg, rem_next;
    logic [plai_pkg::VAL_W-1:0]    base_reg, base_next;
    logic                          neg_reg, neg_next;

    logic [plai_pkg::VAL_W-1:0]    diff;
    logic [plai_pkg::VAL_W-1:0]    mag;
    logic [plai_pkg::OFF_W-1:0]    off_abs;
    logic [plai_pkg::POS_W:0]      rem_sh;
    logic                          fits;
    logic [plai_pkg::VAL_W-1:0]    quo;

    // operand preparation
    always_comb
    begin
        diff    = end_val - begin_val;
        mag     = diff[plai_pkg::VAL_W-1] ? (-diff) : diff;
        off_abs = off[plai_pkg::OFF_W-1] ? (-off) : off;
    end

    // restoring divide step
    always_comb
    begin
        rem_sh = {rem_reg, prod_reg[plai_pkg::PROD_W-1]};
        fits   = rem_sh >= {1'b0, span_reg};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plai_pkg::L_IDLE: if (start) state_next = plai_pkg::L_MUL;
            plai_pkg::L_MUL:
                if (cnt_reg == CNT_W'(MUL_STEPS - 1)) state_next = plai_pkg::L_DIV;
            plai_pkg::L_DIV:
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = plai_pkg::L_DONE;
            plai_pkg::L_DONE: state_next = plai_pkg::L_IDLE;
            default: state_next = plai_pkg::L_IDLE;
        endcase
    end

    // datapath updates
    always_comb
    begin
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        mult_next  = mult_reg;
        span_next  = span_reg;
        rem_next   = rem_reg;
        base_next  = base_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            plai_pkg::L_IDLE:
            begin
                if (start)
                begin
                    cnt_next   = '0;
                    prod_next  = '0;
                    mcand_next = plai_pkg::PROD_W'(mag);
                    mult_next  = off_abs[plai_pkg::POS_W-1:0];
                    span_next  = span;
                    rem_next   = '0;
                    base_next  = begin_val;
                    neg_next   = diff[plai_pkg::VAL_W-1] ^ off[plai_pkg::OFF_W-1];
                end
            end
            plai_pkg::L_MUL:
            begin
                if (mult_reg[0])
                begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[plai_pkg::PROD_W-2:0], 1'b0};
                mult_next  = {1'b0, mult_reg[plai_pkg::POS_W-1:1]};
                cnt_next   = (cnt_reg == CNT_W'(MUL_STEPS - 1)) ? '0 : cnt_reg + 1'b1;
            end
            plai_pkg::L_DIV:
            begin
                rem_next  = fits ? plai_pkg::POS_W'(rem_sh - {1'b0, span_reg})
                                 : rem_sh[plai_pkg::POS_W-1:0];
                prod_next = {prod_reg[plai_pkg::PROD_W-2:0], fits};
                cnt_next  = cnt_reg + 1'b1;
            end
            plai_pkg::L_DONE:
            begin
                cnt_next = '0;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plai_pkg::L_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
        span_reg  <= span_next;
        rem_reg   <= rem_next;
        base_reg  <= base_next;
        neg_reg   <= neg_next;
    end

    // outputs
    always_comb
    begin
        quo    = prod_reg[plai_pkg::VAL_W-1:0];
        busy   = state_reg != plai_pkg::L_IDLE;
        done   = state_reg == plai_pkg::L_DONE;
        result = base_reg + (neg_reg ? (-quo) : quo);
    end

`ifndef SYNTHESIS
    a_mul_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == plai_pkg::L_MUL |-> cnt_reg < CNT_W'(MUL_STEPS))
        else $error("multiply step count out of range");
    a_div_follows_mul: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == plai_pkg::L_DIV) |-> $past(state_reg == plai_pkg::L_MUL))
        else $error("divide entered without multiply");
    a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == plai_pkg::L_DIV))
        else $error("done without divide");
`endif

endmodule

[src/piecewise_linear_anchor_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_anchor_interpolator_unit
// Rebuilds one sample of a compressed block from stored anchors.
// ----------------------------------------------------------------------------
// An anchor write loads the cell named by slot. A query at index 0, at or
// past the last index, or on an empty block goes straight to the finish
// state, which loads the output register. Other queries with no anchors in
// use go to the calc state, which starts the interpolation unit (10 multiply
// steps, 74 divide steps, then its done state), and then to the finish state.
// Queries with anchors first rotate the anchor ring twice (one pass counts
// the anchors at or below the index, one pass picks the bounding anchors),
// then go to the finish state for a degenerate segment or else to the calc
// state. One query is in flight at a time; the result waits while the output
// register is full and stalled, and the next item is taken in the cycle after
// the result has moved into the output register.
module piecewise_linear_anchor_interpolator_unit #(
    parameter int unsigned MAX_ANCHORS = 64,
    parameter int unsigned BLOCK_SIZE  = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [5:0]  slot,
    input  logic [9:0]  anchor_position,
    input  logic [63:0] anchor_level,
    input  logic signed [31:0] anchor_step,
    input  logic [9:0]  query_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] sample_out
);

    localparam int unsigned CW = $clog2(MAX_ANCHORS + 1);

    // configuration registers
    logic [10:0] block_length_reg;
    logic [63:0] first_sample_reg;
    logic [63:0] final_sample_reg;
    logic [6:0]  anchors_in_use_reg;

    plai_pkg::state_t state_reg, state_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [CW-1:0]  c_reg, c_next;
    logic [9:0]     idx_reg, idx_next;
    logic signed [plai_pkg::OFF_W-1:0] sb_reg, sb_next, se_reg, se_next;
    logic [63:0]    bv_reg, bv_next, ev_reg, ev_next;
    logic [63:0]    res_reg, res_next;
    logic [63:0]    out_data_reg;
    logic           out_valid_reg;

    logic           in_xfer;
    logic           wr_xfer;
    logic           out_load;
    logic           shift_en;
    logic [10:0]    size;
    logic [CW-1:0]  count;
    logic           lerp_start;
    logic [63:0]    lerp_begin, lerp_end;
    logic signed [plai_pkg::OFF_W-1:0] lerp_off, lerp_span_s;
    logic           lerp_busy, lerp_done;
    logic [63:0]    lerp_result;
    logic [63:0]    step_ext;

    plai_pkg::anchor_t wr_anchor;
    plai_pkg::anchor_t cell_q [MAX_ANCHORS];
    plai_pkg::anchor_t head;

    assign cfg_ready = 1'b1;
    assign in_stall  = state_reg != plai_pkg::ST_IDLE;
    assign in_xfer   = in_valid && !in_stall;
    assign wr_xfer   = in_xfer && (mode == plai_pkg::MODE_WRITE);
    assign shift_en  = (state_reg == plai_pkg::ST_COUNT) || (state_reg == plai_pkg::ST_SELECT);
    assign head      = cell_q[0];

    // clamped block size and anchor count
    always_comb
    begin
        size  = (block_length_reg > 11'(BLOCK_SIZE)) ? 11'(BLOCK_SIZE) : block_length_reg;
        count = (9'(anchors_in_use_reg) > 9'(MAX_ANCHORS)) ? CW'(MAX_ANCHORS)
                                                           : CW'(anchors_in_use_reg);
        wr_anchor.pos  = anchor_position;
        wr_anchor.val  = anchor_level;
        wr_anchor.step = anchor_step;
        step_ext       = 64'(signed'(head.step));
    end

    // configuration transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg   <= '0;
            first_sample_reg   <= '0;
            final_sample_reg   <= '0;
            anchors_in_use_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                plai_pkg::CFG_BLOCK_LENGTH:   block_length_reg   <= cfg_data[10:0];
                plai_pkg::CFG_FIRST_SAMPLE:   first_sample_reg   <= cfg_data;
                plai_pkg::CFG_FINAL_SAMPLE:   final_sample_reg   <= cfg_data;
                plai_pkg::CFG_ANCHORS_IN_USE: anchors_in_use_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // anchor ring, cell 0 is the head
    for (genvar i = 0; i < MAX_ANCHORS; i++)
    begin : g_cell
        plai_cell u_cell (
            .clk         (clk),
            .load_en     (wr_xfer && (8'(slot) == 8'(i))),
            .load_anchor (wr_anchor),
            .shift_en    (shift_en),
            .shift_in    (cell_q[(i + 1) % MAX_ANCHORS]),
            .cur         (cell_q[i])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plai_pkg::ST_IDLE:
            begin
                if (in_xfer && mode == plai_pkg::MODE_QUERY)
                begin
                    if (size == '0 || query_index == '0 || (11'(query_index) + 11'd1) >= size)
                        state_next = plai_pkg::ST_FINISH;
                    else if (count == '0)
                        state_next = plai_pkg::ST_CALC;
                    else
                        state_next = plai_pkg::ST_COUNT;
                end
            end
            plai_pkg::ST_COUNT:
                if (k_reg == CW'(MAX_ANCHORS - 1)) state_next = plai_pkg::ST_SELECT;
            plai_pkg::ST_SELECT:
            begin
                if (k_reg == CW'(MAX_ANCHORS - 1))
                    state_next = (se_next <= sb_next) ? plai_pkg::ST_FINISH : plai_pkg::ST_CALC;
            end
            plai_pkg::ST_CALC:
                if (lerp_done) state_next = plai_pkg::ST_FINISH;
            plai_pkg::ST_FINISH:
                if (out_load) state_next = plai_pkg::ST_IDLE;
            default: state_next = plai_pkg::ST_IDLE;
        endcase
    end

    // query datapath
    always_comb
    begin
        k_next     = k_reg;
        c_next     = c_reg;
        idx_next   = idx_reg;
        sb_next    = sb_reg;
        se_next    = se_reg;
        bv_next    = bv_reg;
        ev_next    = ev_reg;
        res_next   = res_reg;
        lerp_start = 1'b0;
        unique case (state_reg)
            plai_pkg::ST_IDLE:
            begin
                idx_next = query_index;
                k_next   = '0;
                c_next   = '0;
                sb_next  = '0;
                bv_next  = first_sample_reg;
                se_next  = plai_pkg::OFF_W'(size) - plai_pkg::OFF_W'(1);
                ev_next  = final_sample_reg;
                if (size == '0)
                    res_next = '0;
                else if (query_index == '0)
                    res_next = first_sample_reg;
                else
                    res_next = final_sample_reg;
            end
            plai_pkg::ST_COUNT:
            begin
                if (k_reg < count && head.pos <= idx_reg)
                    c_next = c_reg + 1'b1;
                k_next = (k_reg == CW'(MAX_ANCHORS - 1)) ? '0 : k_reg + 1'b1;
            end
            plai_pkg::ST_SELECT:
            begin
                if (c_reg != '0 && (k_reg + 1'b1) == c_reg)
                begin
                    sb_next = plai_pkg::OFF_W'(head.pos);
                    bv_next = head.val;
                end
                if (k_reg == c_reg && c_reg < count)
                begin
                    se_next = plai_pkg::OFF_W'(head.pos) - plai_pkg::OFF_W'(1);
                    ev_next = head.val - step_ext;
                end
                if (k_reg == CW'(MAX_ANCHORS - 1))
                    res_next = bv_next;
                k_next = (k_reg == CW'(MAX_ANCHORS - 1)) ? '0 : k_reg + 1'b1;
            end
            plai_pkg::ST_CALC:
            begin
                lerp_start = !lerp_busy && !lerp_done;
                if (lerp_done)
                    res_next = lerp_result;
            end
            plai_pkg::ST_FINISH: ;
            default: ;
        endcase
    end

    // operands of the interpolation unit
    always_comb
    begin
        lerp_begin  = bv_reg;
        lerp_end    = ev_reg;
        lerp_off    = plai_pkg::OFF_W'(idx_reg) - sb_reg;
        lerp_span_s = se_reg - sb_reg;
    end

    plai_lerp u_lerp (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (lerp_start),
        .begin_val (lerp_begin),
        .end_val   (lerp_end),
        .off       (lerp_off),
        .span      (lerp_span_s[plai_pkg::POS_W-1:0]),
        .busy      (lerp_busy),
        .done      (lerp_done),
        .result    (lerp_result)
    );

    // output register transfer
    assign out_load  = (state_reg == plai_pkg::ST_FINISH) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign sample_out = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plai_pkg::ST_IDLE;
            k_reg         <= '0;
            c_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            c_reg     <= c_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        sb_reg  <= sb_next;
        se_reg  <= se_next;
        bv_reg  <= bv_next;
        ev_reg  <= ev_next;
        res_reg <= res_next;
        if (out_load)
            out_data_reg <= res_reg;
    end

`ifndef SYNTHESIS
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == plai_pkg::ST_FINISH))
        else $error("result without finish");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == plai_pkg::ST_SELECT |-> c_reg <= count)
        else $error("anchor count exceeds anchors in use");
    a_lerp_only_calc: assert property (@(posedge clk) disable iff (!rst_n)
        lerp_busy |-> state_reg == plai_pkg::ST_CALC)
        else $error("interpolation unit busy outside calc");
    a_ring_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == plai_pkg::ST_IDLE |-> k_reg == '0)
        else $error("ring not aligned when idle");
`endif

endmodule
